// File: rtl/core/acr_pkg.sv
// Shared types, register indexes, gain table and range limits for the
// auto-ranging accelerometer low-pass block. No dependencies.
`timescale 1ns / 1ps

package acr_pkg;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int SH_W    = 12;   // raw word after the precision shift
    localparam int GAIN_W  = 14;
    localparam int OFF_W   = 21;
    localparam int ALPHA_W = 16;
    localparam int FILT_W  = 24;
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 29;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PRECISION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Z     = 3'd4;

    // Precision modes
    localparam logic [1:0] PM_8BIT  = 2'd0;
    localparam logic [1:0] PM_10BIT = 2'd1;

    // Full-scale codes
    localparam logic [1:0] FS_2G  = 2'd0;
    localparam logic [1:0] FS_4G  = 2'd1;
    localparam logic [1:0] FS_8G  = 2'd2;
    localparam logic [1:0] FS_16G = 2'd3;

    // Range windows: 1.9 g, 3.9 g, 7.9 g in Q.16
    localparam logic signed [FILT_W-1:0] LIM_2G = 24'sd124518;
    localparam logic signed [FILT_W-1:0] LIM_4G = 24'sd255590;
    localparam logic signed [FILT_W-1:0] LIM_8G = 24'sd517734;

    localparam logic signed [FILT_W-1:0] SAT_MAX = 24'sh7FFFFF;
    localparam logic signed [FILT_W-1:0] SAT_MIN = 24'sh800000;

    // Reset values
    localparam logic [1:0]         PM_RESET    = 2'd2;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd52429;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
    } t_in;

    typedef struct packed {
        logic signed [FILT_W-1:0] filt_x;
        logic signed [FILT_W-1:0] filt_y;
        logic signed [FILT_W-1:0] filt_z;
        logic [1:0]               range_code;
        logic                     range_changed;
    } t_out;

    typedef struct packed {
        logic [1:0]              precision_mode;
        logic [ALPHA_W-1:0]      filter_alpha;
        logic signed [OFF_W-1:0] offset_x;
        logic signed [OFF_W-1:0] offset_y;
        logic signed [OFF_W-1:0] offset_z;
    } t_cfg;

    // Q0.16 gain per precision and full scale; mode three acts as 12-bit
    function automatic logic [GAIN_W-1:0] gain_of(input logic [1:0] pm,
                                                  input logic [1:0] fs);
        logic [GAIN_W-1:0] g;
        case (pm)
            PM_8BIT: begin
                case (fs)
                    FS_2G:   g = 14'd1024;
                    FS_4G:   g = 14'd2049;
                    FS_8G:   g = 14'd4097;
                    default: g = 14'd12293;
                endcase
            end
            PM_10BIT: begin
                case (fs)
                    FS_2G:   g = 14'd256;
                    FS_4G:   g = 14'd512;
                    FS_8G:   g = 14'd1024;
                    default: g = 14'd3074;
                endcase
            end
            default: begin
                case (fs)
                    FS_2G:   g = 14'd64;
                    FS_4G:   g = 14'd128;
                    FS_8G:   g = 14'd256;
                    default: g = 14'd768;
                endcase
            end
        endcase
        return g;
    endfunction

endpackage

// File: rtl/core/acr_cfg.sv
// Configuration register file: precision, filter weight, axis offsets.
// Depends on acr_pkg.
`timescale 1ns / 1ps

module acr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [acr_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [acr_pkg::OFF_W-1:0]      i_data,
    output acr_pkg::t_cfg                  o_cfg
);
    import acr_pkg::*;

    t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.precision_mode <= PM_RESET;
            r_cfg.filter_alpha   <= ALPHA_RESET;
            r_cfg.offset_x       <= '0;
            r_cfg.offset_y       <= '0;
            r_cfg.offset_z       <= '0;
        end else if (i_wr_en) begin
            case (i_index)
                REG_PRECISION: r_cfg.precision_mode <= i_data[1:0];
                REG_ALPHA:     r_cfg.filter_alpha   <= i_data[ALPHA_W-1:0];
                REG_OFF_X:     r_cfg.offset_x       <= i_data;
                REG_OFF_Y:     r_cfg.offset_y       <= i_data;
                REG_OFF_Z:     r_cfg.offset_z       <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/acr_mul.sv
// Shared signed multiplier with a registered product.
// Depends on acr_pkg.
`timescale 1ns / 1ps

module acr_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [acr_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [acr_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [acr_pkg::PROD_W-1:0]   o_prod
);
    import acr_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // One product per enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/acr_fit.sv
// Range window check for one filtered axis value.
// Depends on acr_pkg.
`timescale 1ns / 1ps

module acr_fit (
    input  logic signed [acr_pkg::FILT_W-1:0] i_val,
    output logic [2:0]                        o_fit
);
    import acr_pkg::*;

    // Bit k set when -T_k <= v <= T_k
    assign o_fit[0] = (i_val >= -LIM_2G) && (i_val <= LIM_2G);
    assign o_fit[1] = (i_val >= -LIM_4G) && (i_val <= LIM_4G);
    assign o_fit[2] = (i_val >= -LIM_8G) && (i_val <= LIM_8G);

endmodule

// File: rtl/core/accel_autorange_lowpass.sv
// Top level of the auto-ranging accelerometer low-pass filter: sequencer and datapath.
// Depends on acr_pkg, acr_cfg, acr_mul, acr_fit.
`timescale 1ns / 1ps

// One sample beat in, one result beat out. Each axis is shifted to the
// selected precision, scaled by the gain for the current full scale, has its
// offset removed and is blended with its previous filtered value
// (alpha*old + (1-alpha)*new, rounded half up, saturated to Q7.16). Then the
// smallest full scale whose window (1.9/3.9/7.9 g) holds all three axes is
// selected; it sets the gain from the next sample on, and range_changed marks
// a switch. A single multiplier does all the products: four steps per axis,
// so a sample holds the block from acceptance through the accept step, 12 axis
// steps, the range step and the output step, which also waits while the
// previous result has not been taken. Input ready is low during that time. The
// config port always accepts; write it only while the block is idle.
module accel_autorange_lowpass (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [acr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acr_pkg::OFF_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  acr_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output acr_pkg::t_out                  o_out_data
);
    import acr_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GAIN = 3'd1;
    localparam logic [2:0] ST_OLD  = 3'd2;
    localparam logic [2:0] ST_NEW  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_RNG  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [1:0] AX_LAST = 2'd2;

    t_cfg w_cfg;

    logic [2:0]                r_state;
    logic [1:0]                r_axis;
    logic signed [RAW_W-1:0]   r_raw  [0:2];
    logic signed [FILT_W-1:0]  r_filt [0:2];
    logic [1:0]                r_fs;
    logic signed [MUL_B_W-1:0] r_smp;
    logic signed [PROD_W-1:0]  r_acc;
    logic [2:0]                r_fit;
    logic                      r_chk;
    logic [1:0]                r_chk_ax;
    logic                      r_out_valid;
    t_out                      r_out;

    logic                      w_in_acc;
    logic                      w_out_load;
    logic signed [RAW_W-1:0]   w_raw;
    logic signed [SH_W-1:0]    w_sh;
    logic [GAIN_W-1:0]         w_gain;
    logic signed [OFF_W-1:0]   w_off;
    logic signed [FILT_W-1:0]  w_old;
    logic                      w_mul_en;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [31:0]        w_q;
    logic signed [FILT_W-1:0]  w_sat;
    logic [2:0]                w_fit;
    logic [1:0]                w_next;

    // Configuration registers
    acr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // Precision shift of the current axis word (floor)
    assign w_raw = r_raw[r_axis];
    always_comb begin
        case (w_cfg.precision_mode)
            PM_8BIT:  w_sh = {{4{w_raw[15]}}, w_raw[15:8]};
            PM_10BIT: w_sh = {{2{w_raw[15]}}, w_raw[15:6]};
            default:  w_sh = w_raw[15:4];
        endcase
    end

    assign w_gain = gain_of(w_cfg.precision_mode, r_fs);
    assign w_old  = r_filt[r_axis];

    always_comb begin
        case (r_axis)
            2'd0:    w_off = w_cfg.offset_x;
            2'd1:    w_off = w_cfg.offset_y;
            default: w_off = w_cfg.offset_z;
        endcase
    end

    // Multiplier operand select per step
    always_comb begin
        w_mul_en = 1'b1;
        case (r_state)
            ST_GAIN: begin
                w_mul_a = {4'b0, w_gain};
                w_mul_b = {{(MUL_B_W-SH_W){w_sh[SH_W-1]}}, w_sh};
            end
            ST_OLD: begin
                w_mul_a = {2'b0, w_cfg.filter_alpha};
                w_mul_b = {{(MUL_B_W-FILT_W){w_old[FILT_W-1]}}, w_old};
            end
            ST_NEW: begin
                w_mul_a = 18'sd65536 - $signed({2'b0, w_cfg.filter_alpha});
                w_mul_b = r_smp;
            end
            default: begin
                w_mul_en = 1'b0;
                w_mul_a  = '0;
                w_mul_b  = '0;
            end
        endcase
    end

    acr_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Blend, round half up, floor shift, saturate
    assign w_sum = {r_acc[PROD_W-1], r_acc} + {w_prod[PROD_W-1], w_prod}
                 + 48'sd32768;
    assign w_q   = w_sum[SUM_W-1:16];
    always_comb begin
        if (w_q[31:23] == 9'h000 || w_q[31:23] == 9'h1FF) begin
            w_sat = w_q[FILT_W-1:0];
        end else if (w_q[31]) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = SAT_MAX;
        end
    end

    // Window check of the axis stored in the previous cycle
    acr_fit u_fit (
        .i_val (r_filt[r_chk_ax]),
        .o_fit (w_fit)
    );

    // Smallest range that holds all three axes
    always_comb begin
        if (r_fit[0]) begin
            w_next = FS_2G;
        end else if (r_fit[1]) begin
            w_next = FS_4G;
        end else if (r_fit[2]) begin
            w_next = FS_8G;
        end else begin
            w_next = FS_16G;
        end
    end

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= '0;
            r_fs        <= FS_2G;
            r_fit       <= 3'b111;
            r_chk       <= 1'b0;
            r_chk_ax    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_filt[i] <= '0;
            end
        end else begin
            if (r_chk) begin
                r_fit <= r_fit & w_fit;
                r_chk <= 1'b0;
            end
            if (r_out_valid && i_out_ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_axis  <= '0;
                        r_fit   <= 3'b111;
                        r_state <= ST_GAIN;
                    end
                end
                ST_GAIN: r_state <= ST_OLD;
                ST_OLD:  r_state <= ST_NEW;
                ST_NEW:  r_state <= ST_SUM;
                ST_SUM: begin
                    r_filt[r_axis] <= w_sat;
                    r_chk          <= 1'b1;
                    r_chk_ax       <= r_axis;
                    if (r_axis == AX_LAST) begin
                        r_state <= ST_RNG;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_GAIN;
                    end
                end
                ST_RNG:  r_state <= ST_OUT;
                ST_OUT: begin
                    if (w_out_load) begin
                        r_out_valid <= 1'b1;
                        r_fs        <= w_next;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_raw[0] <= i_in_data.raw_x;
            r_raw[1] <= i_in_data.raw_y;
            r_raw[2] <= i_in_data.raw_z;
        end
        if (r_state == ST_OLD) begin
            r_smp <= w_prod[MUL_B_W-1:0]
                   - {{(MUL_B_W-OFF_W){w_off[OFF_W-1]}}, w_off};
        end
        if (r_state == ST_NEW) begin
            r_acc <= w_prod;
        end
        if (w_out_load) begin
            r_out.filt_x        <= r_filt[0];
            r_out.filt_y        <= r_filt[1];
            r_out.filt_z        <= r_filt[2];
            r_out.range_code    <= w_next;
            r_out.range_changed <= (w_next != r_fs);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A sample starts at the first axis with the gain step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_GAIN) && (r_axis == 2'd0))
        else $error("sample did not start at first axis");

    // The shown range is the one in force for the next sample
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.range_code == r_fs))
        else $error("shown range differs from range in force");

    // Window checks only follow an axis update
    a_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> (r_state == ST_GAIN) || (r_state == ST_RNG))
        else $error("window check outside its slot");

    // Axis counter stays within three axes
    a_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis != 2'd3)
        else $error("axis counter out of range");
`endif

endmodule

// File: tb/acr_check_pkg.sv
// Scoreboard for the auto-ranging accelerometer low-pass block: register shadow,
// per-axis filter and range prediction, and in-order result checking.
// Depends on acr_pkg.
`timescale 1ns / 1ps

package acr_check_pkg;
    import acr_pkg::*;

    localparam int N_AXES = 3;

    class autorange_scoreboard;
        logic [1:0]         precision;
        logic [ALPHA_W-1:0] alpha;
        logic [1:0]         full_scale;
        longint             offset   [N_AXES];
        longint             filt     [N_AXES];
        longint             gain_q16 [3][4];
        t_out               expected_results [$];
        int                 errors;

        function new();
            // rows: 8-bit, 10-bit, 12-bit; columns: 2/4/8/16 g
            gain_q16 = '{'{1024, 2049, 4097, 12293},
                         '{256, 512, 1024, 3074},
                         '{64, 128, 256, 768}};
            precision  = PM_RESET;
            alpha      = ALPHA_RESET;
            full_scale = FS_2G;
            errors     = 0;
            foreach (offset[i]) begin
                offset[i] = 0;
                filt[i]   = 0;
            end
        endfunction

        // Register write as seen on the config channel; unknown indexes do nothing
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFF_W-1:0] data);
            case (idx)
                REG_PRECISION: precision = data[1:0];
                REG_ALPHA:     alpha = data[ALPHA_W-1:0];
                REG_OFF_X:     offset[0] = longint'($signed(data));
                REG_OFF_Y:     offset[1] = longint'($signed(data));
                REG_OFF_Z:     offset[2] = longint'($signed(data));
                default: ;
            endcase
        endfunction

        function bit all_fit(longint lim);
            foreach (filt[i])
                if (filt[i] < -lim || filt[i] > lim)
                    return 1'b0;
            return 1'b1;
        endfunction

        // Advance the filter state by one sample and queue the result it yields
        function void note_sample(t_in s);
            longint     raw [N_AXES];
            longint     g, smp, acc, v;
            int         row, shift, i;
            logic [1:0] next_fs;
            t_out       r;
            raw[0] = longint'($signed(s.raw_x));
            raw[1] = longint'($signed(s.raw_y));
            raw[2] = longint'($signed(s.raw_z));
            // mode three behaves as 12-bit
            case (precision)
                PM_8BIT:  row = 0;
                PM_10BIT: row = 1;
                default:  row = 2;
            endcase
            shift = 8 - 2 * row;
            g = gain_q16[row][full_scale];
            for (i = 0; i < N_AXES; i++) begin
                smp = (raw[i] >>> shift) * g - offset[i];
                acc = longint'(alpha) * filt[i] + (65536 - longint'(alpha)) * smp;
                v = (acc + 32768) >>> 16;
                if (v > longint'(SAT_MAX))
                    v = longint'(SAT_MAX);
                if (v < longint'(SAT_MIN))
                    v = longint'(SAT_MIN);
                filt[i] = v;
            end
            // smallest window that holds all three axes
            if (all_fit(longint'(LIM_2G)))
                next_fs = FS_2G;
            else if (all_fit(longint'(LIM_4G)))
                next_fs = FS_4G;
            else if (all_fit(longint'(LIM_8G)))
                next_fs = FS_8G;
            else
                next_fs = FS_16G;
            r.filt_x        = filt[0][FILT_W-1:0];
            r.filt_y        = filt[1][FILT_W-1:0];
            r.filt_z        = filt[2][FILT_W-1:0];
            r.range_code    = next_fs;
            r.range_changed = (next_fs != full_scale);
            full_scale = next_fs;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [FILT_W-1:0] want,
                                    logic signed [FILT_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with no sample pending: expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("filt_x", want.filt_x, got.filt_x);
            compare_field("filt_y", want.filt_y, got.filt_y);
            compare_field("filt_z", want.filt_z, got.filt_z);
            compare_field("range_code", {22'd0, want.range_code}, {22'd0, got.range_code});
            compare_field("range_changed", {23'd0, want.range_changed},
                          {23'd0, got.range_changed});
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

// File: tb/testbench.sv
// Top-level testbench for accel_autorange_lowpass: directed and random samples,
// config changes between phases, random idling on the sample channel and back-pressure on the result channel.
// Depends on acr_pkg, acr_check_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
    import acr_pkg::*;
    import acr_check_pkg::*;

    localparam int RESULT_LATENCY  = 24;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int N_PHASES        = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam logic [CFG_IDX_W-1:0] REG_LAST = REG_OFF_Z;
    localparam logic [CFG_IDX_W-1:0] REG_TOP  = {CFG_IDX_W{1'b1}};
    localparam logic [RAW_W-1:0] RAW_MAX  = 16'h7FFF;
    localparam logic [RAW_W-1:0] RAW_MIN  = 16'h8000;
    localparam logic [RAW_W-1:0] RAW_NEG1 = 16'hFFFF;
    localparam logic [RAW_W-1:0] RAW_ONE  = 16'h0001;
    localparam logic [OFF_W-1:0] OFF_MAX  = 21'h0FFFFF;
    localparam logic [OFF_W-1:0] OFF_MIN  = 21'h100000;
    localparam logic [OFF_W-1:0] OFF_NEG1 = 21'h1FFFFF;
    localparam logic [1:0]       PM_MODE3 = 2'd3;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [OFF_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out                 out_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    autorange_scoreboard scoreboard = new();

    accel_autorange_lowpass dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Beat monitor: every handshake goes to the scoreboard
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                scoreboard.check_result(out_data);
            if (in_valid && in_ready)
                scoreboard.note_sample(in_data);
            if (cfg_valid && cfg_ready)
                scoreboard.write_reg(cfg_index, cfg_data);
        end
    end

    // Result sink: random stalls, or a counted hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** accel_autorange_lowpass: FAILED **");
        $finish;
    end

    // Offer one sample beat, idling first at random; valid stays up after acceptance
    task automatic send_sample(input t_in s);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_vec(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                            input logic [RAW_W-1:0] z);
        t_in s;
        s.raw_x = x;
        s.raw_y = y;
        s.raw_z = z;
        send_sample(s);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (scoreboard.pending() != 0);
    endtask

    // Close a group of samples and let the block go idle
    task automatic end_group();
        in_valid <= 1'b0;
        wait_drained();
        repeat (RESULT_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes all registers plus one write to an unused index
    task automatic program_config(input logic [OFF_W-1:0] pm_word,
                                  input logic [OFF_W-1:0] alpha_word,
                                  input logic [OFF_W-1:0] ox,
                                  input logic [OFF_W-1:0] oy,
                                  input logic [OFF_W-1:0] oz);
        write_reg(CFG_IDX_W'($urandom_range(REG_TOP, REG_LAST + 1)), OFF_W'($urandom));
        write_reg(REG_PRECISION, pm_word);
        write_reg(REG_ALPHA, alpha_word);
        write_reg(REG_OFF_X, ox);
        write_reg(REG_OFF_Y, oy);
        write_reg(REG_OFF_Z, oz);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [OFF_W-1:0] random_offset();
        case ($urandom_range(4))
            0:       return '0;
            1:       return OFF_MIN;
            2:       return OFF_MAX;
            3:       return OFF_W'($urandom);
            default: return OFF_W'($urandom_range(400000) - 200000);
        endcase
    endfunction

    task automatic random_config();
        logic [OFF_W-1:0]   alpha_word;
        logic [ALPHA_W-1:0] a;
        case ($urandom_range(4))
            0:       a = '0;
            1:       a = '1;
            2:       a = ALPHA_W'($urandom);
            3:       a = ALPHA_W'($urandom_range(16384));
            default: a = ALPHA_RESET;
        endcase
        // upper data bits are don't-care for the narrow registers
        alpha_word = OFF_W'($urandom);
        alpha_word[ALPHA_W-1:0] = a;
        program_config(OFF_W'($urandom), alpha_word, random_offset(), random_offset(),
                       random_offset());
    endtask

    function automatic logic [RAW_W-1:0] random_axis();
        logic [RAW_W-1:0] mag;
        case ($urandom_range(7))
            0, 1, 2, 3: return RAW_W'($urandom);
            4, 5:       return RAW_W'($urandom_range(2047) - 1024);
            6: begin
                case ($urandom_range(3))
                    0:       return RAW_MAX;
                    1:       return RAW_MIN;
                    2:       return '0;
                    default: return RAW_NEG1;
                endcase
            end
            default: begin
                mag = RAW_W'($urandom_range(32767, 16384));
                return $urandom_range(1) ? mag : -mag;
            end
        endcase
    endfunction

    // Half the time a steady vector with sensor noise, so the filter settles and ranges move
    function automatic t_in random_sample(input t_in steady);
        t_in s;
        if ($urandom_range(1)) begin
            s.raw_x = steady.raw_x + RAW_W'($urandom_range(255)) - RAW_W'(128);
            s.raw_y = steady.raw_y + RAW_W'($urandom_range(255)) - RAW_W'(128);
            s.raw_z = steady.raw_z + RAW_W'($urandom_range(255)) - RAW_W'(128);
        end else begin
            s.raw_x = random_axis();
            s.raw_y = random_axis();
            s.raw_z = random_axis();
        end
        return s;
    endfunction

    initial begin
        t_in steady;
        int  ph, k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: field extremes
        send_vec('0, '0, '0);
        send_vec(RAW_MAX, RAW_MAX, RAW_MAX);
        send_vec(RAW_MAX, RAW_MAX, RAW_MAX);
        send_vec(RAW_MIN, RAW_MIN, RAW_MIN);
        send_vec(RAW_NEG1, RAW_ONE, RAW_MIN);
        end_group();

        // 8-bit, alpha zero: output tracks the sample and climbs through all ranges
        program_config({19'd0, PM_8BIT}, '0, '0, '0, '0);
        repeat (4) send_vec(RAW_MAX, RAW_MAX, RAW_MAX);
        send_vec(RAW_MIN, RAW_MIN, RAW_MIN);
        repeat (2) send_vec('0, '0, '0);
        end_group();

        // Mode three, heaviest smoothing, extreme offsets
        program_config({19'd0, PM_MODE3}, {5'd0, 16'hFFFF}, OFF_MIN, OFF_MAX, OFF_NEG1);
        send_vec(RAW_MAX, RAW_MIN, '0);
        send_vec('0, '0, '0);
        send_vec(RAW_MIN, RAW_MAX, RAW_NEG1);
        end_group();

        // 10-bit, alpha zero: reaches the corrected 16 g gain
        program_config({19'd0, PM_10BIT}, '0, '0, OFF_MAX, OFF_MIN);
        repeat (4) send_vec(RAW_MAX, RAW_MAX, RAW_MAX);
        send_vec(RAW_MIN, RAW_MIN, RAW_MIN);
        end_group();

        // Random phases, each with its own configuration and idling mix
        for (ph = 0; ph < N_PHASES; ph++) begin
            random_config();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            // long sink hold-off while samples keep coming: fills the block
            if (ph == 0)
                hold_cycles = HOLD_CYCLES;
            steady.raw_x = random_axis();
            steady.raw_y = random_axis();
            steady.raw_z = random_axis();
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 5 && k == ITEMS_PER_PHASE / 2) begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                send_sample(random_sample(steady));
            end
            end_group();
        end

        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("** accel_autorange_lowpass: PASSED **");
        else
            $display("** accel_autorange_lowpass: FAILED **");
        $finish;
    end

endmodule

// File: accel_autorange_lowpass.f
rtl/core/acr_pkg.sv
rtl/core/acr_cfg.sv
rtl/core/acr_mul.sv
rtl/core/acr_fit.sv
rtl/core/accel_autorange_lowpass.sv
tb/acr_check_pkg.sv
tb/testbench.sv
